FILE: hw/rtl/sfg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfg_pkg
// Shared constants, types and codes of the spring force generator.
// ----------------------------------------------------------------------------
package sfg_pkg;

    // Fixed-point format of positions, lengths and forces.
    localparam int FRAC_BITS  = 16;
    localparam int UNIT_BITS  = 30;
    localparam int SHIFT      = FRAC_BITS + UNIT_BITS;

    // Data path widths.
    localparam int DW         = 32;
    localparam int MAGW       = DW + 1;
    localparam int SUMW       = 2 * DW + 2;
    localparam int LENW       = SUMW / 2 + 1;
    localparam int REMW       = LENW + 3;
    localparam int KPW        = DW + LENW;
    localparam int QW         = UNIT_BITS + 1;
    localparam int PRODW      = KPW + QW;
    localparam int RESW       = PRODW - SHIFT;

    // Pipeline depths.
    localparam int SQ_STEPS   = LENW;
    localparam int DIV_STEPS  = QW;

    // Queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Packed stream widths.
    localparam int IN_TDW     = 6 * DW;
    localparam int OUT_TDW    = ((3 * DW + 2 + 7) / 8) * 8;

    // Configuration register indexes.
    localparam int CFG_IW     = 2;
    typedef enum logic [CFG_IW-1:0] {
        REG_SPRING_CONSTANT = 2'd0,
        REG_REST_LENGTH     = 2'd1,
        REG_VARIANT         = 2'd2
    } t_reg_idx;

    // Spring variants; the spare code behaves as the plain spring.
    typedef enum logic [1:0] {
        VAR_PLAIN  = 2'd0,
        VAR_ANCHOR = 2'd1,
        VAR_BUNGEE = 2'd2,
        VAR_SPARE  = 2'd3
    } t_variant;

    typedef struct packed {
        logic [DW-1:0] spring_constant;
        logic [DW-1:0] rest_length;
        t_variant      variant;
    } t_cfg;

    // Offset vector in sign and magnitude form.
    typedef struct packed {
        logic [2:0]           dneg;
        logic [2:0][MAGW-1:0] mag;
    } t_vec;

    // Item handed from front to back.
    typedef struct packed {
        t_vec            vec;
        logic [SUMW-1:0] sum;
    } t_front_item;

    // Control carried alongside the division.
    typedef struct packed {
        logic [2:0]     neg;
        logic           slack;
        logic           zero;
        logic [KPW-1:0] kp;
    } t_ctl;

endpackage

FILE: hw/rtl/spring_force_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_force_generator_core
// Three-dimensional Hooke spring force from a particle and an other-end point.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the output is not held, set by
// the bit-per-stage square root and divider pipelines and the split force
// multiplier.
// Reset: synchronous active-low; clears all valid flags and the queue and
// loads stiffness 1.0, rest length 1.0 and the plain spring variant.
module spring_force_generator_core import sfg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // particle_x, particle_y, particle_z, other_x, other_y, other_z
    input  logic [IN_TDW-1:0]  i_s_axis_tdata,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // force_x, force_y, force_z, applied, saturated, zero fill
    output logic [OUT_TDW-1:0] o_m_axis_tdata,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    input  logic               i_cfg_we,
    input  logic [CFG_IW-1:0]  i_cfg_idx,
    input  logic [DW-1:0]      i_cfg_data
);

    t_cfg        r_cfg;
    logic        w_push, w_pop, w_full, w_empty;
    t_front_item w_fr_item, w_q_item;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spring_constant <= DW'(65536);
            r_cfg.rest_length     <= DW'(65536);
            r_cfg.variant         <= VAR_PLAIN;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_SPRING_CONSTANT: r_cfg.spring_constant <= i_cfg_data;
                REG_REST_LENGTH:     r_cfg.rest_length     <= i_cfg_data;
                REG_VARIANT:         r_cfg.variant         <= t_variant'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    sfg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_fr_item)
    );

    sfg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fr_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    sfg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_item  (w_q_item),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule

FILE: hw/rtl/sfg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfg_front
// Accepts position pairs, forms the offset and its squared length.
// ----------------------------------------------------------------------------
module sfg_front import sfg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [IN_TDW-1:0] i_data,
    input  logic              i_full,
    output logic              o_push,
    output t_front_item       o_item
);

    logic        r_a_v, r_b_v;
    t_vec        r_a_vec, n_a_vec;
    t_front_item r_b_item, n_b_item;
    logic        w_en;

    // The two stages move together unless the last one cannot push.
    assign w_en    = !r_b_v || !i_full;
    assign o_ready = w_en;
    assign o_push  = r_b_v && !i_full;
    assign o_item  = r_b_item;

    // Offset components as sign and magnitude.
    always_comb begin
        logic signed [MAGW-1:0] d;
        for (int i = 0; i < 3; i++) begin
            d = $signed({i_data[i*DW+DW-1], i_data[i*DW +: DW]})
              - $signed({i_data[(i+3)*DW+DW-1], i_data[(i+3)*DW +: DW]});
            n_a_vec.dneg[i] = d[MAGW-1];
            n_a_vec.mag[i]  = d[MAGW-1] ? MAGW'(-d) : MAGW'(d);
        end
    end

    // Sum of squares.
    always_comb begin
        n_b_item.vec = r_a_vec;
        n_b_item.sum = '0;
        for (int i = 0; i < 3; i++) begin
            n_b_item.sum = n_b_item.sum
                         + SUMW'(r_a_vec.mag[i] * r_a_vec.mag[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_vec  <= n_a_vec;
            r_b_item <= n_b_item;
        end
    end

endmodule

FILE: hw/rtl/sfg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfg_queue
// Short queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module sfg_queue import sfg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_front_item i_item,
    input  logic        i_pop,
    output t_front_item o_item,
    output logic        o_full,
    output logic        o_empty
);

    t_front_item          r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_AW:0]     r_cnt;
    logic                 w_push, w_pop;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (FIFO_AW+1)'(w_push) - (FIFO_AW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_item;
    end

endmodule

FILE: hw/rtl/sfg_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfg_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module sfg_sqrt import sfg_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [SUMW-1:0] i_rad,
    input  t_vec            i_vec,
    output logic            o_valid,
    output logic [LENW-1:0] o_root,
    output t_vec            o_vec
);

    logic            r_v    [SQ_STEPS];
    logic [REMW-1:0] r_rem  [SQ_STEPS];
    logic [LENW-1:0] r_root [SQ_STEPS];
    logic [SUMW-1:0] r_rad  [SQ_STEPS];
    t_vec            r_vec  [SQ_STEPS];

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_stage
        localparam int BIT = SQ_STEPS - 1 - s;
        logic            w_v;
        logic [REMW-1:0] w_rem, w_rem2, w_trial;
        logic [LENW-1:0] w_root;
        logic [SUMW-1:0] w_rad;
        t_vec            w_vec;

        if (s == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = i_rad;
            assign w_vec  = i_vec;
        end else begin : g_next
            assign w_v    = r_v[s-1];
            assign w_rem  = r_rem[s-1];
            assign w_root = r_root[s-1];
            assign w_rad  = r_rad[s-1];
            assign w_vec  = r_vec[s-1];
        end

        // Bring down two radicand bits and try the next root bit.
        assign w_rem2  = {w_rem[REMW-3:0], w_rad[2*BIT+1 -: 2]};
        assign w_trial = REMW'({w_root, 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s] <= w_rad;
                r_vec[s] <= w_vec;
                if (w_rem2 >= w_trial) begin
                    r_rem[s]  <= w_rem2 - w_trial;
                    r_root[s] <= {w_root[LENW-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= w_rem2;
                    r_root[s] <= {w_root[LENW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[SQ_STEPS-1];
    assign o_root  = r_root[SQ_STEPS-1];
    assign o_vec   = r_vec[SQ_STEPS-1];

endmodule

FILE: hw/rtl/sfg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfg_div
// Three-lane pipelined restoring divider for the unit direction.
// ----------------------------------------------------------------------------
module sfg_div import sfg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [LENW-1:0]      i_len,
    input  logic [2:0][MAGW-1:0] i_mag,
    input  t_ctl                 i_ctl,
    output logic                 o_valid,
    output logic [2:0][QW-1:0]   o_q,
    output t_ctl                 o_ctl
);

    logic                 r_v   [DIV_STEPS];
    logic [LENW-1:0]      r_len [DIV_STEPS];
    logic [2:0][LENW-1:0] r_rem [DIV_STEPS];
    logic [2:0][QW-1:0]   r_q   [DIV_STEPS];
    t_ctl                 r_ctl [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
        logic                 w_v;
        logic [LENW-1:0]      w_len;
        logic [2:0][LENW:0]   w_rem2;
        logic [2:0][QW-1:0]   w_q;
        t_ctl                 w_ctl;

        // The quotient stays below 2^QW, so the first partial remainder is
        // the magnitude itself.
        if (s == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_len = i_len;
            assign w_ctl = i_ctl;
            assign w_q   = '0;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign w_rem2[l] = (LENW+1)'(i_mag[l]);
            end
        end else begin : g_next
            assign w_v   = r_v[s-1];
            assign w_len = r_len[s-1];
            assign w_ctl = r_ctl[s-1];
            assign w_q   = r_q[s-1];
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign w_rem2[l] = {r_rem[s-1][l], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v;
            end
        end

        // One quotient bit per lane.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[s] <= w_len;
                r_ctl[s] <= w_ctl;
                for (int l = 0; l < 3; l++) begin
                    if (w_rem2[l] >= (LENW+1)'(w_len)) begin
                        r_rem[s][l] <= LENW'(w_rem2[l] - (LENW+1)'(w_len));
                        r_q[s][l]   <= {w_q[l][QW-2:0], 1'b1};
                    end else begin
                        r_rem[s][l] <= LENW'(w_rem2[l]);
                        r_q[s][l]   <= {w_q[l][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_q     = r_q[DIV_STEPS-1];
    assign o_ctl   = r_ctl[DIV_STEPS-1];

endmodule

FILE: hw/rtl/sfg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfg_back
// Length, extension, direction and force scaling with saturation.
// ----------------------------------------------------------------------------
module sfg_back import sfg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_empty,
    input  t_front_item        i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [OUT_TDW-1:0] o_data
);

    logic                 w_en;
    logic                 w_sq_v;
    logic [LENW-1:0]      w_len;
    t_vec                 w_sq_vec;

    logic                 r_c1_v, r_c2_v;
    logic [LENW-1:0]      r_c1_len, r_c2_len;
    logic [LENW-1:0]      r_c1_ext;
    t_vec                 r_c1_vec, r_c2_vec;
    t_ctl                 r_c1_ctl, r_c2_ctl;
    logic [LENW-1:0]      n_ext;
    t_ctl                 n_ctl;

    logic                 w_dv_v;
    logic [2:0][QW-1:0]   w_q;
    t_ctl                 w_dv_ctl;

    logic                 r_m1_v, r_m2_v;
    t_ctl                 r_m1_ctl, r_m2_ctl;
    logic [2:0][DW+QW-1:0]          r_plo;
    logic [2:0][KPW-DW+QW-1:0]      r_phi;
    logic [2:0][PRODW-1:0]          r_prod;

    logic                 r_out_v;
    logic [OUT_TDW-1:0]   r_out, n_out;
    logic                 w_mneg;
    logic [LENW-1:0]      w_rest;

    // The whole back pipeline advances unless the result is held.
    assign w_en    = !r_out_v || i_ready;
    assign o_pop   = w_en && !i_empty;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    sfg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (o_pop),
        .i_rad   (i_item.sum),
        .i_vec   (i_item.vec),
        .o_valid (w_sq_v),
        .o_root  (w_len),
        .o_vec   (w_sq_vec)
    );

    // Classify: extension, force sign and the no-force cases.
    assign w_rest = LENW'(i_cfg.rest_length);
    always_comb begin
        if (w_len >= w_rest) begin
            n_ext  = w_len - w_rest;
            w_mneg = 1'b1;
        end else begin
            n_ext  = w_rest - w_len;
            w_mneg = !(i_cfg.variant == VAR_ANCHOR || i_cfg.variant == VAR_BUNGEE);
        end
        n_ctl.kp    = '0;
        n_ctl.zero  = (w_len == '0);
        n_ctl.slack = (i_cfg.variant == VAR_BUNGEE) && (w_len <= w_rest);
        for (int i = 0; i < 3; i++) begin
            n_ctl.neg[i] = w_sq_vec.dneg[i] != w_mneg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_c1_v  <= w_sq_v;
            r_c2_v  <= r_c1_v;
            r_m1_v  <= w_dv_v;
            r_m2_v  <= r_m1_v;
            r_out_v <= r_m2_v;
        end
    end

    // Stiffness times extension.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_len <= w_len;
            r_c1_ext <= n_ext;
            r_c1_vec <= w_sq_vec;
            r_c1_ctl <= n_ctl;
            r_c2_len <= r_c1_len;
            r_c2_vec <= r_c1_vec;
            r_c2_ctl.neg   <= r_c1_ctl.neg;
            r_c2_ctl.slack <= r_c1_ctl.slack;
            r_c2_ctl.zero  <= r_c1_ctl.zero;
            r_c2_ctl.kp    <= KPW'(i_cfg.spring_constant * r_c1_ext);
        end
    end

    sfg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c2_v),
        .i_len   (r_c2_len),
        .i_mag   (r_c2_vec.mag),
        .i_ctl   (r_c2_ctl),
        .o_valid (w_dv_v),
        .o_q     (w_q),
        .o_ctl   (w_dv_ctl)
    );

    // Force magnitude: split product, then recombine.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_ctl <= w_dv_ctl;
            r_m2_ctl <= r_m1_ctl;
            for (int i = 0; i < 3; i++) begin
                r_plo[i]  <= (DW+QW)'(w_dv_ctl.kp[DW-1:0] * w_q[i]);
                r_phi[i]  <= (KPW-DW+QW)'(w_dv_ctl.kp[KPW-1:DW] * w_q[i]);
                r_prod[i] <= PRODW'(r_plo[i]) + (PRODW'(r_phi[i]) << DW);
            end
        end
    end

    // Scale, clamp and pack the result.
    always_comb begin
        logic [RESW-1:0] res;
        logic [RESW-1:0] limit;
        logic [DW-1:0]   mag;
        logic            sat;
        n_out = '0;
        sat   = 1'b0;
        for (int i = 0; i < 3; i++) begin
            res   = r_prod[i][PRODW-1:SHIFT];
            limit = r_m2_ctl.neg[i] ? RESW'(33'h0_8000_0000) : RESW'(33'h0_7FFF_FFFF);
            if (res > limit) begin
                mag = DW'(limit);
                sat = 1'b1;
            end else begin
                mag = DW'(res);
            end
            n_out[i*DW +: DW] = r_m2_ctl.neg[i] ? DW'(-mag) : mag;
        end
        if (r_m2_ctl.slack || r_m2_ctl.zero) begin
            n_out[3*DW-1:0] = '0;
            sat = 1'b0;
        end
        n_out[3*DW]   = !r_m2_ctl.slack;
        n_out[3*DW+1] = sat;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_out <= n_out;
    end

endmodule

FILE: hw/rtl/sfg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfg_checker
// Port-level checks of the spring force generator, bound to the top level.
// ----------------------------------------------------------------------------
module sfg_checker import sfg_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic [OUT_TDW-1:0] o_m_axis_tdata,
    input logic               o_m_axis_tvalid,
    input logic               i_m_axis_tready
);

    // A held result keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("held result changed");

    // A slack bungee gives no force and no clamp.
    a_slack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[3*DW] |->
        o_m_axis_tdata[3*DW-1:0] == '0 && !o_m_axis_tdata[3*DW+1])
        else $error("slack result carries force");

    // A clamp shows up as a component at a range limit.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[3*DW+1] |->
        o_m_axis_tdata[DW-1:0] == 32'h7FFF_FFFF || o_m_axis_tdata[DW-1:0] == 32'h8000_0000
        || o_m_axis_tdata[2*DW-1:DW] == 32'h7FFF_FFFF
        || o_m_axis_tdata[2*DW-1:DW] == 32'h8000_0000
        || o_m_axis_tdata[3*DW-1:2*DW] == 32'h7FFF_FFFF
        || o_m_axis_tdata[3*DW-1:2*DW] == 32'h8000_0000)
        else $error("clamp flag without a clamped component");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind spring_force_generator_core sfg_checker u_sfg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-dimensional spring force generator.
// Random and directed particle and other-end positions are streamed in under
// several stiffness, rest length and variant settings, with random stalls on
// both sides. A scoreboard predicts each force and checks every result in
// order.
// ----------------------------------------------------------------------------
module testbench;
    import sfg_pkg::*;

    // Expected fields of one force result.
    typedef struct {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic        applied;
        logic        sat;
    } force_t;

    // Predicts forces from positions and compares them with the block output.
    class force_board;
        force_t      pending[$];
        logic [31:0] stiffness;
        logic [31:0] rest_len;
        t_variant    mode;
        int          mismatches;

        function void load_reset();
            stiffness = 32'h0001_0000;
            rest_len  = 32'h0001_0000;
            mode      = VAR_PLAIN;
        endfunction

        // Works out the force for one accepted request and queues it.
        function void note_request(logic [IN_TDW-1:0] data);
            force_t       f;
            logic [32:0]  mag[3];
            logic         dneg[3];
            logic [127:0] sum, root, rem, trial, ext, unit, prod, lim;
            logic signed [33:0] d;
            logic         mneg, neg;
            logic [31:0]  res[3];
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                d = $signed(data[32*i +: 32]) - $signed(data[32*(i+3) +: 32]);
                dneg[i] = d < 0;
                mag[i] = dneg[i] ? 33'(-d) : 33'(d);
                sum += 128'(mag[i]) * 128'(mag[i]);
            end
            // Bit-serial integer square root of the squared length.
            root = 0;
            rem = 0;
            for (int i = 33; i >= 0; i--) begin
                rem = (rem << 2) | 128'(sum[2*i +: 2]);
                trial = (root << 2) | 128'd1;
                if (rem >= trial) begin
                    rem -= trial;
                    root = (root << 1) | 128'd1;
                end else begin
                    root = root << 1;
                end
            end
            f.fx = 0;
            f.fy = 0;
            f.fz = 0;
            f.applied = 1'b1;
            f.sat = 1'b0;
            if (mode == VAR_BUNGEE && root <= 128'(rest_len)) begin
                f.applied = 1'b0;
            end else if (root != 0) begin
                if (root >= 128'(rest_len)) begin
                    ext = root - 128'(rest_len);
                    mneg = 1'b1;
                end else begin
                    ext = 128'(rest_len) - root;
                    mneg = 1'b0;
                end
                if (mode != VAR_ANCHOR && mode != VAR_BUNGEE) mneg = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    unit = (128'(mag[i]) << UNIT_BITS) / root;
                    prod = (128'(stiffness) * ext * unit) >> SHIFT;
                    neg = dneg[i] != mneg;
                    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
                    if (prod > lim) begin
                        prod = lim;
                        f.sat = 1'b1;
                    end
                    res[i] = neg ? 32'(-prod) : 32'(prod);
                end
                f.fx = res[0];
                f.fy = res[1];
                f.fz = res[2];
            end
            pending.push_back(f);
        endfunction

        // Compares one result with the oldest expected force.
        function void check_result(logic [OUT_TDW-1:0] data);
            force_t f;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", data);
                return;
            end
            f = pending.pop_front();
            if (data[31:0] !== f.fx || data[63:32] !== f.fy || data[95:64] !== f.fz
                    || data[96] !== f.applied || data[97] !== f.sat
                    || data[OUT_TDW-1:98] !== '0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("force mismatch: exp %h %h %h a%b s%b, got %h %h %h a%b s%b",
                             f.fx, f.fy, f.fz, f.applied, f.sat, data[31:0],
                             data[63:32], data[95:64], data[96], data[97]);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic [IN_TDW-1:0]  i_s_axis_tdata = '0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [OUT_TDW-1:0] o_m_axis_tdata;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_IW-1:0]  i_cfg_idx = '0;
    logic [DW-1:0]      i_cfg_data = '0;

    force_board board = new();
    bit         quiet = 0;
    int         stall_left = 0;
    longint     cycles = 0;
    localparam longint CYCLE_LIMIT = 600000;

    spring_force_generator_core dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Accepted requests feed the predictor; accepted results are checked.
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            board.note_request(i_s_axis_tdata);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_result(o_m_axis_tdata);
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Result side stalls in random bursts, except in the quiet part.
    always @(negedge i_clk) begin
        if (quiet) begin
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 18);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Sends one request, with an occasional idle burst in front of it.
    // Valid stays high after acceptance until the next request or the drain.
    task automatic send_request(logic [IN_TDW-1:0] data);
        bit taken;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_s_axis_tdata <= data;
        i_s_axis_tvalid <= 1'b1;
        do begin
            @(posedge i_clk);
            taken = o_s_axis_tready;
            @(negedge i_clk);
        end while (!taken);
    endtask

    // Waits for every expected result, then lets the pipeline settle.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            REG_SPRING_CONSTANT: board.stiffness = value;
            REG_REST_LENGTH:     board.rest_len = value;
            default:             board.mode = t_variant'(value[1:0]);
        endcase
    endtask

    function automatic logic [IN_TDW-1:0] pack_pos(logic [31:0] p[3], logic [31:0] o[3]);
        return {o[2], o[1], o[0], p[2], p[1], p[0]};
    endfunction

    // Random positions: mostly near the rest length, some far apart, some raw.
    task automatic send_random(int count);
        logic [31:0] p[3], o[3];
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 9);
            for (int i = 0; i < 3; i++) begin
                o[i] = $urandom();
                if (sel < 5)
                    p[i] = o[i] + 32'($signed($urandom_range(0, 32'h40000))
                                      - 32'sh20000);
                else if (sel < 7)
                    p[i] = o[i] + 32'($signed($urandom_range(0, 32'h4000000))
                                      - 32'sh2000000);
                else
                    p[i] = $urandom();
            end
            send_request(pack_pos(p, o));
        end
    endtask

    // Directed positions: zero length, axis extremes, exact rest length.
    task automatic send_directed();
        logic [31:0] p[3], o[3];
        p = '{0, 0, 0};
        o = '{0, 0, 0};
        send_request(pack_pos(p, o));
        p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        o = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_request(pack_pos(p, o));
        send_request(pack_pos(o, p));
        p = '{32'h7FFF_FFFF, 32'h8000_0000, 0};
        o = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        send_request(pack_pos(p, o));
        p = '{board.rest_len, 0, 0};
        o = '{0, 0, 0};
        send_request(pack_pos(p, o));
        p = '{0, 32'h0000_8000, 32'hFFFF_8000};
        send_request(pack_pos(p, o));
    endtask

    initial begin
        board.load_reset();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings first.
        send_directed();
        send_random(100);
        drain();

        // Stiff plain spring with zero rest length drives saturation.
        write_reg(REG_SPRING_CONSTANT, 32'hFFFF_FFFF);
        write_reg(REG_REST_LENGTH, 32'h0);
        send_directed();
        send_random(60);
        drain();

        // Anchored spring with zero stiffness and maximal rest length.
        write_reg(REG_SPRING_CONSTANT, 32'h0);
        write_reg(REG_REST_LENGTH, 32'hFFFF_FFFF);
        write_reg(REG_VARIANT, 32'(VAR_ANCHOR));
        send_directed();
        send_random(40);
        drain();

        // Anchored spring, moderate values.
        write_reg(REG_SPRING_CONSTANT, 32'h0000_8000);
        write_reg(REG_REST_LENGTH, 32'h0002_0000);
        send_directed();
        send_random(60);
        drain();

        // Bungee; upper data bits of the variant write are ignored.
        write_reg(REG_SPRING_CONSTANT, 32'h0003_0000);
        write_reg(REG_REST_LENGTH, 32'h0001_8000);
        write_reg(REG_VARIANT, 32'hFFFF_FFFE);
        send_directed();
        send_random(60);
        drain();

        // Bungee with random stiffness and rest length.
        write_reg(REG_SPRING_CONSTANT, $urandom());
        write_reg(REG_REST_LENGTH, $urandom_range(0, 32'h0400_0000));
        send_directed();
        send_random(60);
        drain();

        // Spare variant code acts as the plain spring; no idling from here on.
        write_reg(REG_SPRING_CONSTANT, $urandom_range(0, 32'h0010_0000));
        write_reg(REG_REST_LENGTH, $urandom_range(0, 32'h0004_0000));
        write_reg(REG_VARIANT, 32'(VAR_SPARE));
        quiet = 1;
        send_directed();
        send_random(60);
        drain();

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/sfg_pkg.sv
hw/rtl/sfg_front.sv
hw/rtl/sfg_queue.sv
hw/rtl/sfg_sqrt.sv
hw/rtl/sfg_div.sv
hw/rtl/sfg_back.sv
hw/rtl/spring_force_generator_core.sv
hw/rtl/sfg_checker.sv
verif/testbench.sv
